// ===== sv/vector_spring_smoother_assert.svh =====
// Assertion macros for the vector spring smoother.
`ifndef VECTOR_SPRING_SMOOTHER_ASSERT_SVH
`define VECTOR_SPRING_SMOOTHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define VSS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vector_spring_smoother: same-cycle check failed");
`define VSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vector_spring_smoother: next-cycle check failed");
`else
`define VSS_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define VSS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/vss_pkg.sv =====
// Package: constants, sequencer states and fixed-point helpers of the spring smoother.
package vss_pkg;

   localparam int VAL_W      = 32;
   localparam int AXES       = 3;
   localparam int AXIS_W     = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int DIV_STEPS  = 65;
   localparam int SQRT_STEPS = 32;
   localparam int CNT_W      = 7;

   localparam logic [15:0] SPEED_RESET = 16'd256;

   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   localparam logic REG_SPEED = 1'b0;
   localparam logic REG_MAXV  = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_WW,
      S_WDT,
      S_K,
      S_N2SQ,
      S_DEN,
      S_DMUL,
      S_N1,
      S_VDIV,
      S_VSTORE,
      S_LIM,
      S_SQ,
      S_SQEND,
      S_CMP,
      S_SQRT,
      S_SMUL,
      S_SLOAD,
      S_SDIV,
      S_SSTORE,
      S_PMUL,
      S_PADD,
      S_DONE
   } state_type;

   // saturate a 33-bit signed sum to 32 bits
   function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x[32] != x[31]) begin
         r = x[32] ? VAL_MIN : VAL_MAX;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // apply sign to an unsigned magnitude and saturate
   function automatic logic signed [31:0] sat_mag(input logic neg, input logic [64:0] m);
      logic signed [31:0] r;
      if (!neg) begin
         r = (m > 65'h0_7FFF_FFFF) ? VAL_MAX : $signed(m[31:0]);
      end else begin
         r = (m > 65'h0_8000_0000) ? VAL_MIN : $signed(32'd0 - m[31:0]);
      end
      return r;
   endfunction

   // |x| of a 32-bit signed value
   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      logic [32:0] t;
      t = x[31] ? (33'd0 - {x[31], x}) : {x[31], x};
      return t[31:0];
   endfunction

   // x / 2^16, rounded to nearest, ties away from zero
   function automatic logic signed [48:0] round16(input logic [63:0] x);
      logic [63:0]        m;
      logic [47:0]        r;
      logic signed [48:0] t;
      m = x[63] ? (64'd0 - x) : x;
      r = 48'((m + 64'd32768) >> 16);
      t = $signed({1'b0, r});
      return x[63] ? (49'sd0 - t) : t;
   endfunction

endpackage

// ===== sv/vector_spring_smoother.sv =====
// Top level: critically damped spring smoother over a 3-axis position.
//
//  channel | ports                | direction | handshake
//  --------+----------------------+-----------+---------------------------
//  req     | req_cur_*, req_tgt_*,| in        | req_valid / req_stall
//          | req_delta_time       |           |
//  rsp     | rsp_pos_*, rsp_vel_* | out       | rsp_valid / rsp_stall
//  csr     | csr_p*               | in/out    | APB-style, pready tied high
//
// A word runs the velocity divides; with clamping on it also passes the length check,
// and when the velocity length exceeds max_velocity it also takes a square root and
// a second divider pass. The time per word is set by the shared restoring divider
// (one quotient per axis per pass) and the square root.
// req_stall is high while a word is in work.
// A finished word sits in the output register; the next word is taken while
// it waits, only the hand-off of the following result waits on rsp_stall.
// Reset is synchronous: config returns to interp_speed 1.0, no clamp, velocity zero.
module vector_spring_smoother (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [vss_pkg::VAL_W-1:0] req_cur_x,
   input  logic signed [vss_pkg::VAL_W-1:0] req_cur_y,
   input  logic signed [vss_pkg::VAL_W-1:0] req_cur_z,
   input  logic signed [vss_pkg::VAL_W-1:0] req_tgt_x,
   input  logic signed [vss_pkg::VAL_W-1:0] req_tgt_y,
   input  logic signed [vss_pkg::VAL_W-1:0] req_tgt_z,
   input  logic [15:0]                     req_delta_time,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [vss_pkg::VAL_W-1:0] rsp_pos_x,
   output logic signed [vss_pkg::VAL_W-1:0] rsp_pos_y,
   output logic signed [vss_pkg::VAL_W-1:0] rsp_pos_z,
   output logic signed [vss_pkg::VAL_W-1:0] rsp_vel_x,
   output logic signed [vss_pkg::VAL_W-1:0] rsp_vel_y,
   output logic signed [vss_pkg::VAL_W-1:0] rsp_vel_z,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import vss_pkg::*;

   `include "vector_spring_smoother_assert.svh"

   state_type state_ff, state_in;

   // config
   logic [15:0] speed_ff, speed_in;
   logic [30:0] maxv_ff, maxv_in;

   // captured word
   logic [15:0]        dt_ff, dt_in;
   logic signed [31:0] cur_ff [AXES];
   logic signed [31:0] cur_in [AXES];
   logic signed [31:0] tgt_ff [AXES];
   logic signed [31:0] tgt_in [AXES];

   // spring state and results
   logic signed [31:0] vel_ff [AXES];
   logic signed [31:0] vel_in [AXES];
   logic signed [31:0] pos_ff [AXES];
   logic signed [31:0] pos_in [AXES];
   logic signed [31:0] opos_ff [AXES];
   logic signed [31:0] opos_in [AXES];
   logic signed [31:0] ovel_ff [AXES];
   logic signed [31:0] ovel_in [AXES];
   logic               rsp_valid_ff, rsp_valid_in;

   // shared multiplier
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_ff, prod_in;

   // coefficients
   logic [31:0] ww_ff, ww_in;
   logic [24:0] n2_ff, n2_in;
   logic [31:0] k_ff, k_in;
   logic [32:0] den_ff, den_in;

   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // shared restoring divider
   logic [64:0] div_num_ff, div_num_in;
   logic [33:0] div_rem_ff, div_rem_in;
   logic [32:0] div_den_ff, div_den_in;
   logic [64:0] div_quo_ff, div_quo_in;
   logic        div_neg_ff, div_neg_in;

   // length clamp
   logic [63:0] sum_ff, sum_in;
   logic [61:0] lim_ff, lim_in;
   logic [63:0] sq_x_ff, sq_x_in;
   logic [33:0] sq_rem_ff, sq_rem_in;
   logic [31:0] sq_root_ff, sq_root_in;

   logic req_take, rsp_load, axis_last, div_last, sqrt_last, cfg_wr;

   // combinational temporaries
   logic [34:0]        div_sh, div_sub;
   logic               div_ge;
   logic [35:0]        sq_sh, sq_trial, sq_sub;
   logic               sq_ge;
   logic signed [31:0] d_val;
   logic signed [48:0] rs_val;
   logic signed [49:0] n1_val;
   logic [49:0]        n1_mag;
   logic [64:0]        sum_add;

   assign req_take   = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign axis_last  = (axis_ff == AXIS_W'(AXES - 1));
   assign div_last   = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign sqrt_last  = (cnt_ff == CNT_W'(SQRT_STEPS - 1));
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAXV) ? {1'b0, maxv_ff} : {16'd0, speed_ff};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = opos_ff[0];
   assign rsp_pos_y = opos_ff[1];
   assign rsp_pos_z = opos_ff[2];
   assign rsp_vel_x = ovel_ff[0];
   assign rsp_vel_y = ovel_ff[1];
   assign rsp_vel_z = ovel_ff[2];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_take) state_in = S_WW;
         S_WW:     state_in = S_WDT;
         S_WDT:    state_in = S_K;
         S_K:      state_in = S_N2SQ;
         S_N2SQ:   state_in = S_DEN;
         S_DEN:    state_in = S_DMUL;
         S_DMUL:   state_in = S_N1;
         S_N1:     state_in = S_VDIV;
         S_VDIV:   if (div_last) state_in = S_VSTORE;
         S_VSTORE: begin
            if (!axis_last) state_in = S_DMUL;
            else if (maxv_ff != 31'd0) state_in = S_LIM;
            else state_in = S_PMUL;
         end
         S_LIM:    state_in = S_SQ;
         S_SQ:     if (axis_last) state_in = S_SQEND;
         S_SQEND:  state_in = S_CMP;
         S_CMP:    state_in = (sum_ff > {2'b00, lim_ff}) ? S_SQRT : S_PMUL;
         S_SQRT:   if (sqrt_last) state_in = S_SMUL;
         S_SMUL:   state_in = S_SLOAD;
         S_SLOAD:  state_in = S_SDIV;
         S_SDIV:   if (div_last) state_in = S_SSTORE;
         S_SSTORE: state_in = axis_last ? S_PMUL : S_SMUL;
         S_PMUL:   state_in = S_PADD;
         S_PADD:   state_in = axis_last ? S_DONE : S_PMUL;
         S_DONE:   if (rsp_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      speed_in     = speed_ff;
      maxv_in      = maxv_ff;
      dt_in        = dt_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      vel_in       = vel_ff;
      pos_in       = pos_ff;
      opos_in      = opos_ff;
      ovel_in      = ovel_ff;
      rsp_valid_in = rsp_valid_ff;
      ww_in        = ww_ff;
      n2_in        = n2_ff;
      k_in         = k_ff;
      den_in       = den_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_quo_in   = div_quo_ff;
      div_neg_in   = div_neg_ff;
      sum_in       = sum_ff;
      lim_in       = lim_ff;
      sq_x_in      = sq_x_ff;
      sq_rem_in    = sq_rem_ff;
      sq_root_in   = sq_root_ff;
      mul_a        = '0;
      mul_b        = '0;

      // one divider step: shift in a numerator bit, trial subtract
      div_sh  = {div_rem_ff, div_num_ff[64]};
      div_ge  = (div_sh >= {2'b00, div_den_ff});
      div_sub = div_ge ? (div_sh - {2'b00, div_den_ff}) : div_sh;

      // one square root step: two radicand bits per step
      sq_sh    = {sq_rem_ff, sq_x_ff[63:62]};
      sq_trial = {2'b00, sq_root_ff, 2'b01};
      sq_ge    = (sq_sh >= sq_trial);
      sq_sub   = sq_ge ? (sq_sh - sq_trial) : sq_sh;

      d_val   = sat33({cur_ff[axis_ff][31], cur_ff[axis_ff]} -
                      {tgt_ff[axis_ff][31], tgt_ff[axis_ff]});
      rs_val  = round16(prod_ff[63:0]);
      n1_val  = {{18{vel_ff[axis_ff][31]}}, vel_ff[axis_ff]} - {rs_val[48], rs_val};
      n1_mag  = n1_val[49] ? (50'd0 - n1_val) : n1_val;
      sum_add = {1'b0, sum_ff} + {1'b0, prod_ff[63:0]};

      if (cfg_wr) begin
         case (csr_paddr[2])
            REG_SPEED: speed_in = csr_pwdata[15:0];
            REG_MAXV:  maxv_in  = csr_pwdata[30:0];
            default:   speed_in = speed_ff;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               dt_in     = req_delta_time;
               cur_in[0] = req_cur_x;
               cur_in[1] = req_cur_y;
               cur_in[2] = req_cur_z;
               tgt_in[0] = req_tgt_x;
               tgt_in[1] = req_tgt_y;
               tgt_in[2] = req_tgt_z;
            end
         end
         S_WW: begin
            mul_a = {18'd0, speed_ff};
            mul_b = {18'd0, speed_ff};
         end
         S_WDT: begin
            ww_in = prod_ff[31:0];
            mul_a = {18'd0, speed_ff};
            mul_b = {18'd0, dt_ff};
         end
         S_K: begin
            // n2 = 1.0 + w*dt, Q8.24 rounded to Q.16
            n2_in = 25'(33'd65536 + (({1'b0, prod_ff[31:0]} + 33'd128) >> 8));
            mul_a = {2'b00, ww_ff};
            mul_b = {18'd0, dt_ff};
         end
         S_N2SQ: begin
            k_in  = 32'(({1'b0, prod_ff[47:0]} + 49'd32768) >> 16);
            mul_a = {9'd0, n2_ff};
            mul_b = {9'd0, n2_ff};
         end
         S_DEN: begin
            den_in  = 33'(({1'b0, prod_ff[49:0]} + 51'd32768) >> 16);
            axis_in = '0;
         end
         S_DMUL: begin
            mul_a = {{2{d_val[31]}}, d_val};
            mul_b = {2'b00, k_ff};
         end
         S_N1: begin
            // quotient = round(|n1| << 16 / den), done as floor with den/2 added
            div_num_in = {n1_mag[48:0], 16'd0} + {32'd0, den_ff[32:1]};
            div_den_in = den_ff;
            div_rem_in = '0;
            div_quo_in = '0;
            div_neg_in = n1_val[49];
            cnt_in     = '0;
         end
         S_VDIV, S_SDIV: begin
            div_num_in = {div_num_ff[63:0], 1'b0};
            div_rem_in = div_sub[33:0];
            div_quo_in = {div_quo_ff[63:0], div_ge};
            cnt_in     = cnt_ff + CNT_W'(1);
         end
         S_VSTORE: begin
            vel_in[axis_ff] = sat_mag(div_neg_ff, div_quo_ff);
            axis_in         = axis_last ? '0 : axis_ff + AXIS_W'(1);
         end
         S_LIM: begin
            mul_a = {3'd0, maxv_ff};
            mul_b = {3'd0, maxv_ff};
         end
         S_SQ: begin
            // first pass picks up the limit, later ones accumulate squares
            if (axis_ff == '0) begin
               lim_in = prod_ff[61:0];
               sum_in = '0;
            end else begin
               sum_in = sum_add[64] ? '1 : sum_add[63:0];
            end
            mul_a   = {2'b00, mag32(vel_ff[axis_ff])};
            mul_b   = {2'b00, mag32(vel_ff[axis_ff])};
            axis_in = axis_last ? '0 : axis_ff + AXIS_W'(1);
         end
         S_SQEND: begin
            sum_in = sum_add[64] ? '1 : sum_add[63:0];
         end
         S_CMP: begin
            sq_x_in    = sum_ff;
            sq_rem_in  = '0;
            sq_root_in = '0;
            cnt_in     = '0;
         end
         S_SQRT: begin
            sq_x_in    = {sq_x_ff[61:0], 2'b00};
            sq_rem_in  = sq_sub[33:0];
            sq_root_in = {sq_root_ff[30:0], sq_ge};
            cnt_in     = cnt_ff + CNT_W'(1);
         end
         S_SMUL: begin
            mul_a = {2'b00, mag32(vel_ff[axis_ff])};
            mul_b = {3'd0, maxv_ff};
         end
         S_SLOAD: begin
            div_num_in = {2'b00, prod_ff[62:0]} + {34'd0, sq_root_ff[31:1]};
            div_den_in = {1'b0, sq_root_ff};
            div_rem_in = '0;
            div_quo_in = '0;
            div_neg_in = vel_ff[axis_ff][31];
            cnt_in     = '0;
         end
         S_SSTORE: begin
            vel_in[axis_ff] = sat_mag(div_neg_ff, div_quo_ff);
            axis_in         = axis_last ? '0 : axis_ff + AXIS_W'(1);
         end
         S_PMUL: begin
            mul_a = {{2{vel_ff[axis_ff][31]}}, vel_ff[axis_ff]};
            mul_b = {18'd0, dt_ff};
         end
         S_PADD: begin
            pos_in[axis_ff] = sat33({cur_ff[axis_ff][31], cur_ff[axis_ff]} + rs_val[32:0]);
            axis_in         = axis_last ? '0 : axis_ff + AXIS_W'(1);
         end
         S_DONE: begin
            if (rsp_load) begin
               opos_in      = pos_ff;
               ovel_in      = vel_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            axis_in = '0;
         end
      endcase

      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         speed_ff     <= SPEED_RESET;
         maxv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= '0;
         cnt_ff       <= '0;
         for (int i = 0; i < AXES; i++) begin
            vel_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         speed_ff     <= speed_in;
         maxv_ff      <= maxv_in;
         rsp_valid_ff <= rsp_valid_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         vel_ff       <= vel_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff      <= dt_in;
      cur_ff     <= cur_in;
      tgt_ff     <= tgt_in;
      pos_ff     <= pos_in;
      opos_ff    <= opos_in;
      ovel_ff    <= ovel_in;
      prod_ff    <= prod_in;
      ww_ff      <= ww_in;
      n2_ff      <= n2_in;
      k_ff       <= k_in;
      den_ff     <= den_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      div_quo_ff <= div_quo_in;
      div_neg_ff <= div_neg_in;
      sum_ff     <= sum_in;
      lim_ff     <= lim_in;
      sq_x_ff    <= sq_x_in;
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
   end

   // a taken word always starts the coefficient setup
   `VSS_ASSERT_NEXT(a_take_starts, clock, reset, req_take, state_ff == S_WW)
   // divider remainder stays below its divisor when a quotient is used
   `VSS_ASSERT_SAME(a_div_rem, clock, reset,
                    (state_ff == S_VSTORE) || (state_ff == S_SSTORE),
                    div_rem_ff < {1'b0, div_den_ff})
   // a finished word reaches the output register once it is free
   `VSS_ASSERT_NEXT(a_done_shows, clock, reset, rsp_load, rsp_valid_ff)

endmodule

// ===== dv/tb_vector_spring_smoother.sv =====
// Testbench for vector_spring_smoother: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module tb_vector_spring_smoother;
   import vss_pkg::*;

   localparam int  WORD_LATENCY = 500;      // above the slowest word, which takes the clamp path
   localparam int  CYCLE_LIMIT  = 3000000;
   localparam int  HOLD_CYCLES  = 2000;
   localparam longint SAT_MAX   = 64'sd2147483647;
   localparam longint SAT_MIN   = -64'sd2147483648;

   typedef struct {
      logic signed [31:0] cur[3];
      logic signed [31:0] tgt[3];
      logic [15:0]        dt;
   } word_type;

   typedef struct {
      logic signed [31:0] pos[3];
      logic signed [31:0] vel[3];
   } motion_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_cur_x = '0, req_cur_y = '0, req_cur_z = '0;
   logic signed [31:0] req_tgt_x = '0, req_tgt_y = '0, req_tgt_z = '0;
   logic [15:0]        req_delta_time = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic               csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   vector_spring_smoother u_dut (.*);

   // predictor state: config copies plus the velocity it carries between words
   logic [15:0] speed_q88;
   logic [30:0] vmax_q16;
   longint      spring_vel[3];

   motion_type  motion_q[$];     // expected results, oldest first
   int          errors = 0;
   int          cycles = 0;
   bit          stall_en = 1'b0; // random receiver stalls
   bit          gaps_en = 1'b0;  // random sender gaps
   bit          hold_pending = 1'b0;
   motion_type  last_motion;     // newest prediction, used for tracking runs

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_vector_spring_smoother failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint sat32(longint x);
      return (x > SAT_MAX) ? SAT_MAX : (x < SAT_MIN) ? SAT_MIN : x;
   endfunction

   // x / 2^16, nearest, ties away from zero
   function automatic longint rnd16(longint x);
      longint m;
      m = x < 0 ? -x : x;
      m = (m + 32768) >>> 16;
      return x < 0 ? -m : m;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic motion_type smooth_step(word_type it);
      motion_type      o;
      longint          w, dt, k, n2, den, c, d, n1, m, qh, r, q, v, s;
      longint          cur[3];
      longint unsigned sum, lim, len, mu;
      w = longint'(speed_q88);
      dt = longint'(it.dt);
      k = (w * w * dt + 32768) >>> 16;
      n2 = 65536 + ((w * dt + 128) >>> 8);
      den = (n2 * n2 + 32768) >>> 16;
      for (int i = 0; i < 3; i++) begin
         c = longint'(it.cur[i]);
         cur[i] = c;
         d = sat32(c - longint'(it.tgt[i]));
         n1 = spring_vel[i] - rnd16(d * k);
         m = n1 < 0 ? -n1 : n1;
         qh = m / den;
         r = m % den;
         if (qh > (64'sd1 << 32)) begin
            v = n1 < 0 ? SAT_MIN : SAT_MAX;
         end else begin
            q = (qh << 16) + ((r << 16) + den / 2) / den;
            v = sat32(n1 < 0 ? -q : q);
         end
         spring_vel[i] = v;
      end
      // length limit: scale the whole vector, not each axis
      if (vmax_q16 != 0) begin
         sum = 0;
         lim = longint'(vmax_q16) * longint'(vmax_q16);
         for (int i = 0; i < 3; i++) begin
            mu = spring_vel[i] < 0 ? -spring_vel[i] : spring_vel[i];
            sum += mu * mu;
         end
         if (sum > lim) begin
            len = root_floor(sum);
            for (int i = 0; i < 3; i++) begin
               mu = spring_vel[i] < 0 ? -spring_vel[i] : spring_vel[i];
               s = (mu * vmax_q16 + len / 2) / len;
               spring_vel[i] = sat32(spring_vel[i] < 0 ? -s : s);
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         o.vel[i] = spring_vel[i][31:0];
         o.pos[i] = 32'(sat32(cur[i] + rnd16(spring_vel[i] * dt)));
      end
      return o;
   endfunction

   // ---------------------------------------------------------------- helpers
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_word(word_type it);
      int gap;
      gap = gaps_en ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_cur_x <= it.cur[0];  req_cur_y <= it.cur[1];  req_cur_z <= it.cur[2];
      req_tgt_x <= it.tgt[0];  req_tgt_y <= it.tgt[1];  req_tgt_z <= it.tgt[2];
      req_delta_time <= it.dt;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      last_motion = smooth_step(it);
      motion_q.push_back(last_motion);
   endtask

   task automatic csr_write(logic idx, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_SPEED) speed_q88 = data[15:0];
      else vmax_q16 = data[30:0];
   endtask

   // drain everything, then let the datapath settle before touching registers
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (motion_q.size() != 0) @(posedge clock);
      repeat (WORD_LATENCY) @(posedge clock);
   endtask

   task automatic set_regs(logic [15:0] spd, logic [30:0] vmax);
      wait_drained();
      csr_write(REG_SPEED, {16'd0, spd});
      csr_write(REG_MAXV, {1'b0, vmax});
   endtask

   function automatic word_type make_word(bit full, logic [15:0] dt_max);
      word_type it;
      for (int i = 0; i < 3; i++) begin
         if (full) begin
            it.cur[i] = $urandom;
            it.tgt[i] = $urandom;
         end else begin
            it.cur[i] = $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
            it.tgt[i] = $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
         end
      end
      it.dt = full ? 16'($urandom) : 16'($urandom_range(0, dt_max));
      return it;
   endfunction

   function automatic word_type uniform_word(int c, int t, logic [15:0] dt);
      word_type it;
      for (int i = 0; i < 3; i++) begin
         it.cur[i] = c;
         it.tgt[i] = t;
      end
      it.dt = dt;
      return it;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      motion_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (motion_q.size() == 0) begin
            report("unexpected word", rsp_pos_x, 32'd0);
         end else begin
            e = motion_q.pop_front();
            if (rsp_pos_x !== e.pos[0]) report("pos_x", rsp_pos_x, e.pos[0]);
            if (rsp_pos_y !== e.pos[1]) report("pos_y", rsp_pos_y, e.pos[1]);
            if (rsp_pos_z !== e.pos[2]) report("pos_z", rsp_pos_z, e.pos[2]);
            if (rsp_vel_x !== e.vel[0]) report("vel_x", rsp_vel_x, e.vel[0]);
            if (rsp_vel_y !== e.vel[1]) report("vel_y", rsp_vel_y, e.vel[1]);
            if (rsp_vel_z !== e.vel[2]) report("vel_z", rsp_vel_z, e.vel[2]);
         end
      end
   end

   // receiver back-pressure; a hold request freezes the output for a long stretch
   initial forever begin
      int len;
      @(posedge clock);
      if (hold_pending) begin
         hold_pending = 1'b0;
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_stall <= 1'b0;
      end else if (stall_en && $urandom_range(0, 99) < 30) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
         rsp_stall <= 1'b1;
         repeat (len) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- tests
   // reset config (speed 1.0, no clamp): field extremes and a zero time step
   task automatic test_reset_defaults();
      send_word(uniform_word(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
      send_word(uniform_word(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
      send_word(uniform_word(32'h0001_0000, 32'h0, 16'h0));      // zero step keeps velocity
      send_word(uniform_word(32'h0, 32'h0, 16'h0001));
      send_word(uniform_word(32'hFFFF_FFFF, 32'h0000_0001, 16'h8000));
   endtask

   // fast spring with a short step: the divide overflows and saturates
   task automatic test_quotient_overflow();
      set_regs(16'd4096, 31'd0);
      send_word(uniform_word(32'h7FFF_FFFF, 32'h8000_0000, 16'd4096));
      send_word(uniform_word(32'h8000_0000, 32'h7FFF_FFFF, 16'd4096));
      send_word(uniform_word(32'h8000_0000, 32'h7FFF_FFFF, 16'd4096));
   endtask

   // register extremes, clamp on and off
   task automatic test_register_extremes();
      set_regs(16'd0, 31'd0);                   // w = 0: no spring at all
      send_word(uniform_word(32'h1234_5678, 32'h0, 16'hFFFF));
      set_regs(16'hFFFF, 31'h7FFF_FFFF);        // largest clamp limit
      send_word(uniform_word(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
      send_word(uniform_word(32'h0100_0000, 32'h0, 16'h0100));
      set_regs(16'd256, 31'd1);                 // smallest nonzero limit
      send_word(uniform_word(32'h0010_0000, 32'h0, 16'h1000));
      send_word(uniform_word(32'h0, 32'h0, 16'h0));     // zero step, clamp still applies
      set_regs(16'd1024, 31'h0002_0000);        // limit of 2.0
      send_word(uniform_word(32'h0050_0000, 32'hFFF0_0000, 16'h0800));
      send_word(uniform_word(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
      send_word(uniform_word(32'h0, 32'h0, 16'h0400));
   endtask

   // well-formed use: each word, save every 40th, starts at the last predicted position
   task automatic test_tracking(int words);
      word_type it;
      word_type nt;
      for (int n = 0; n < words; n++) begin
         if (n % 40 == 0) begin
            set_regs(16'($urandom_range(1, 4096)),
                     ($urandom_range(0, 1) != 0) ? 31'($urandom_range(0, 32'h0040_0000)) : 31'd0);
            it = make_word(1'b0, 16'h2000);
         end else begin
            it.cur = last_motion.pos;
            if ($urandom_range(0, 19) == 0) begin
               nt = make_word(1'b0, 16'h0);
               it.tgt = nt.tgt;
            end
            it.dt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h1000));
         end
         send_word(it);
      end
   endtask

   // noise: full-range registers, fields full-range or small at random
   task automatic test_noise(int words);
      for (int n = 0; n < words; n++) begin
         if (n % 50 == 0)
            set_regs(16'($urandom), ($urandom_range(0, 2) == 0) ? 31'd0 : 31'($urandom));
         send_word(make_word(1'($urandom_range(0, 1)), 16'hFFFF));
      end
   endtask

   // receiver holds off while the sender keeps offering; input must stall
   task automatic test_backpressure();
      set_regs(16'd512, 31'h0008_0000);
      hold_pending = 1'b1;
      for (int n = 0; n < 12; n++) send_word(make_word(1'b0, 16'h4000));
   endtask

   initial begin
      speed_q88 = SPEED_RESET;
      vmax_q16 = '0;
      spring_vel = '{0, 0, 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_quotient_overflow();
      test_register_extremes();
      stall_en = 1'b1;
      gaps_en = 1'b1;
      test_tracking(520);
      test_noise(250);
      stall_en = 1'b0;
      gaps_en = 1'b0;
      test_backpressure();
      stall_en = 1'b1;
      gaps_en = 1'b1;
      test_noise(40);

      wait_drained();
      if (errors == 0) begin
         $display("tb_vector_spring_smoother passed");
      end else begin
         $display("tb_vector_spring_smoother failed");
      end
      $finish;
   end

endmodule
